/* rtl/tsmd_pkg.sv */
package tsmd_pkg;

  localparam int SENSORS_DEF = 2;
  localparam int HISTORY_DEF = 4;

  localparam int IDX_W   = 4;
  localparam int COUNT_W = 12;
  localparam int TOTAL_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGREE,
    ST_OUT
  } tsmd_state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic scan_en;
    logic hist_shift;
    logic agree_en;
    logic agree_done;
    logic out_valid;
  } tsmd_ctrl_t;

endpackage

/* rtl/tsmd_if.sv */
interface tsmd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         yes_touch;
  logic                         no_touch;
  logic                         timeout_flag;
  logic                         overrun_flag;
  logic [tsmd_pkg::IDX_W-1:0]   sensor_index;
  logic [tsmd_pkg::COUNT_W-1:0] touch_count;

  modport source (
    output valid, yes_touch, no_touch, timeout_flag, overrun_flag,
           sensor_index, touch_count,
    input  ready
  );
  modport sink (
    input  valid, yes_touch, no_touch, timeout_flag, overrun_flag,
           sensor_index, touch_count,
    output ready
  );
endinterface

interface tsmd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         touching;
  logic [tsmd_pkg::IDX_W-1:0]   largest_sensor;
  logic [tsmd_pkg::TOTAL_W-1:0] timeouts_seen;
  logic [tsmd_pkg::TOTAL_W-1:0] overruns_seen;

  modport source (
    output valid, touching, largest_sensor, timeouts_seen, overruns_seen,
    input  ready
  );
  modport sink (
    input  valid, touching, largest_sensor, timeouts_seen, overruns_seen,
    output ready
  );
endinterface

/* rtl/touch_sensor_majority_detector.sv */
// channel   | modport | payload                                               | transaction
// ----------+---------+-------------------------------------------------------+---------------
// in_ch     | sink    | yes_touch, no_touch, timeout_flag, overrun_flag,      | one event
//           |         | sensor_index[3:0], touch_count[11:0]                  |
// out_ch    | source  | touching, largest_sensor[3:0], timeouts_seen[15:0],   | one result
//           |         | overruns_seen[15:0]                                   |
//
// touch event: result valid once the scan (ST_SCAN) and the history check (ST_AGREE) are done,
//   one argmax step per sensor after the first, one history compare per entry after the first,
//   all on one comparator; no new event is accepted until the result is taken and ST_IDLE is back
// any other event gives its result the cycle after acceptance
// in_ready is high only while idle; the result waits in out_ch, a stalled out_ready stalls input
// synchronous active-low reset clears counts, history, touching and both totals
module touch_sensor_majority_detector #(
  parameter int SENSORS = tsmd_pkg::SENSORS_DEF,
  parameter int HISTORY = tsmd_pkg::HISTORY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsmd_in_if.sink    in_ch,
  tsmd_out_if.source out_ch
);

  localparam int CNT_IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int HIST_IDX_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int STEP_W     = (CNT_IDX_W > HIST_IDX_W) ? CNT_IDX_W : HIST_IDX_W;

  tsmd_pkg::tsmd_ctrl_t ctrl;
  logic [STEP_W-1:0]    step;

  // per-sensor last touch counts and the largest-index history (newest at 0)
  logic [tsmd_pkg::COUNT_W-1:0] counts_r [SENSORS];
  logic [tsmd_pkg::IDX_W-1:0]   hist_r   [HISTORY];
  logic                         touch_r;
  logic [tsmd_pkg::TOTAL_W-1:0] tmo_total_r;
  logic [tsmd_pkg::TOTAL_W-1:0] ovr_total_r;

  // argmax and agreement scratch registers
  logic [tsmd_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [tsmd_pkg::COUNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic                         agree_r, agree_nxt;

  logic                         in_fire;
  logic                         idx_ok;
  logic                         plain_evt;
  logic [tsmd_pkg::COUNT_W-1:0] count0_new;
  logic [tsmd_pkg::COUNT_W-1:0] count_k;
  logic [tsmd_pkg::IDX_W-1:0]   hist_k;
  logic                         cmp_hit;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign idx_ok    = ({1'b0, in_ch.sensor_index} < (tsmd_pkg::IDX_W + 1)'(SENSORS));
  assign plain_evt = !in_ch.yes_touch && !in_ch.no_touch;

  // sensor 0's count as it stands after this event's write
  assign count0_new = (in_ch.yes_touch && in_ch.sensor_index == '0) ?
                      in_ch.touch_count : counts_r[0];

  assign count_k = counts_r[step[CNT_IDX_W-1:0]];
  assign hist_k  = hist_r[step[HIST_IDX_W-1:0]];

  tsmd_seq #(
    .SENSORS (SENSORS),
    .HISTORY (HISTORY),
    .STEP_W  (STEP_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_yes    (in_ch.yes_touch),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl),
    .step      (step)
  );

  // shared comparator: count_k > best during the scan, hist_k != newest after
  tsmd_cmp u_cmp (
    .sel_agree (ctrl.agree_en),
    .cnt_a     (count_k),
    .cnt_b     (best_cnt_r),
    .hist_a    (hist_k),
    .hist_b    (hist_r[0]),
    .hit       (cmp_hit)
  );

  always_comb begin
    best_idx_nxt = best_idx_r;
    best_cnt_nxt = best_cnt_r;
    agree_nxt    = agree_r;
    if (in_fire) begin
      // start the argmax at sensor 0
      best_idx_nxt = '0;
      best_cnt_nxt = count0_new;
    end else if (ctrl.scan_en && cmp_hit) begin
      // strictly greater only, so ties keep the lower index
      best_idx_nxt = tsmd_pkg::IDX_W'(step);
      best_cnt_nxt = count_k;
    end
    if (ctrl.hist_shift) begin
      agree_nxt = 1'b1;
    end else if (ctrl.agree_en) begin
      agree_nxt = agree_r && !cmp_hit;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    agree_r    <= agree_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        counts_r[i] <= '0;
      end
      for (int i = 0; i < HISTORY; i++) begin
        hist_r[i] <= '0;
      end
      touch_r     <= 1'b0;
      tmo_total_r <= '0;
      ovr_total_r <= '0;
    end else begin
      // touch event: store the count when the index is in range
      if (in_fire && in_ch.yes_touch && idx_ok) begin
        counts_r[in_ch.sensor_index[CNT_IDX_W-1:0]] <= in_ch.touch_count;
      end
      // neither touch flag: bump the error totals, wrapping
      if (in_fire && plain_evt) begin
        if (in_ch.timeout_flag) begin
          tmo_total_r <= tmo_total_r + tsmd_pkg::TOTAL_W'(1);
        end
        if (in_ch.overrun_flag) begin
          ovr_total_r <= ovr_total_r + tsmd_pkg::TOTAL_W'(1);
        end
      end
      // end of the scan: push the winner into the history
      if (ctrl.hist_shift) begin
        for (int i = HISTORY - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= best_idx_nxt;
      end
      if (ctrl.agree_done) begin
        touch_r <= agree_nxt;
      end
    end
  end

  assign in_ch.ready           = ctrl.in_ready;
  assign out_ch.valid          = ctrl.out_valid;
  assign out_ch.touching       = touch_r;
  assign out_ch.largest_sensor = hist_r[0];
  assign out_ch.timeouts_seen  = tmo_total_r;
  assign out_ch.overruns_seen  = ovr_total_r;

  // history agreement seen all at once, for checking only
  logic hist_equal;
  always_comb begin
    hist_equal = 1'b1;
    for (int i = 1; i < HISTORY; i++) begin
      if (hist_r[i] != hist_r[0]) begin
        hist_equal = 1'b0;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a result is pending");

  a_touch_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.yes_touch) |=> ctrl.scan_en)
    else $error("touch event did not start the scan");

  a_touch_matches: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.agree_done |=> (touch_r == hist_equal))
    else $error("touching disagrees with the history");

  a_winner_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, hist_r[0]} < (tsmd_pkg::IDX_W + 1)'(SENSORS)))
    else $error("largest sensor out of range");

  a_tmo_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && plain_evt && in_ch.timeout_flag) |=>
      (tmo_total_r == $past(tmo_total_r) + tsmd_pkg::TOTAL_W'(1)))
    else $error("timeout total did not advance");

endmodule

/* rtl/tsmd_cmp.sv */
module tsmd_cmp (
  input  logic                         sel_agree,
  input  logic [tsmd_pkg::COUNT_W-1:0] cnt_a,
  input  logic [tsmd_pkg::COUNT_W-1:0] cnt_b,
  input  logic [tsmd_pkg::IDX_W-1:0]   hist_a,
  input  logic [tsmd_pkg::IDX_W-1:0]   hist_b,
  output logic                         hit
);

  logic [tsmd_pkg::COUNT_W-1:0] op_a;
  logic [tsmd_pkg::COUNT_W-1:0] op_b;

  // one comparator: greater-than for the argmax, not-equal for the history
  always_comb begin
    if (sel_agree) begin
      op_a = tsmd_pkg::COUNT_W'(hist_a);
      op_b = tsmd_pkg::COUNT_W'(hist_b);
      hit  = (op_a != op_b);
    end else begin
      op_a = cnt_a;
      op_b = cnt_b;
      hit  = (op_a > op_b);
    end
  end

endmodule

/* rtl/tsmd_seq.sv */
module tsmd_seq #(
  parameter int SENSORS = tsmd_pkg::SENSORS_DEF,
  parameter int HISTORY = tsmd_pkg::HISTORY_DEF,
  parameter int STEP_W  = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_yes,
  input  logic                out_ready,
  output tsmd_pkg::tsmd_ctrl_t ctrl,
  output logic [STEP_W-1:0]   step
);

  tsmd_pkg::tsmd_state_t state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  scan_last;
  logic                  agree_last;

  assign scan_last  = (step_r == STEP_W'(SENSORS - 1));
  assign agree_last = (step_r == STEP_W'(HISTORY - 1));
  assign step       = step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsmd_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      tsmd_pkg::ST_IDLE: begin
        step_nxt = STEP_W'(1);
        if (in_valid) begin
          state_nxt = in_yes ? tsmd_pkg::ST_SCAN : tsmd_pkg::ST_OUT;
        end
      end
      tsmd_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = tsmd_pkg::ST_AGREE;
          step_nxt  = STEP_W'(1);
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      tsmd_pkg::ST_AGREE: begin
        if (agree_last) begin
          state_nxt = tsmd_pkg::ST_OUT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      tsmd_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = tsmd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsmd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      tsmd_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
      tsmd_pkg::ST_SCAN: begin
        ctrl.scan_en    = 1'b1;
        ctrl.hist_shift = scan_last;
      end
      tsmd_pkg::ST_AGREE: begin
        ctrl.agree_en   = 1'b1;
        ctrl.agree_done = agree_last;
      end
      tsmd_pkg::ST_OUT:   ctrl.out_valid = 1'b1;
      default:            ctrl = '0;
    endcase
  end

endmodule
